@@ rtl/core/latency_percentile_stats_assert.svh @@
// Assertion macros shared by the statistics block.
`ifndef LATENCY_PERCENTILE_STATS_ASSERT_SVH
`define LATENCY_PERCENTILE_STATS_ASSERT_SVH
// Check that a condition implies a consequence on the next clock.
`define LPS_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);
// Check that a condition holds at every clock.
`define LPS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`endif

@@ rtl/core/lps_pkg.sv @@
package lps_pkg;
   localparam int MaxSamples = 256;
   localparam int DataW = 32;
   localparam int SumW = 64;
   localparam int AvgW = 40;
   localparam int CntW = 32;
   localparam int PctMedian = 50;
   localparam int PctHigh = 95;
   localparam int PctTail = 99;
   // floor(x/100) == (x*PctRecip) >> PctShift for every x below 2^20
   localparam int PctRecip = 671089;
   localparam int PctShift = 26;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DIV,
      ST_PICK,
      ST_READ,
      ST_READ_TAIL,
      ST_OUT
   } state_type;
endpackage

@@ rtl/core/lps_cell.sv @@
// One entry of the sorted chain: keeps its value, or takes the new word or its
// left neighbor's value so that the row stays ascending.
module lps_cell (
   input  logic        clock,
   input  logic        insert,
   input  logic        valid_here,
   input  logic        left_takes,
   input  logic [31:0] left_value,
   input  logic [31:0] new_value,
   output logic        takes,
   output logic [31:0] value
);
   logic [31:0] value_ff;
   logic [31:0] value_in;

   // A valid entry above the new word moves right; first such entry takes it.
   assign takes = !valid_here || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      if (insert && takes) begin
         value_in = left_takes ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

@@ rtl/core/lps_divider.sv @@
// Restoring divider, one quotient bit a cycle; gives floor(num*256/den)
// saturated to the average width.
module lps_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [39:0] quot
);
   localparam int NumW = 72;
   logic [NumW-1:0] num_ff, num_in;
   logic [32:0]     rem_ff, rem_in;
   logic [NumW-1:0] q_ff, q_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [32:0]     trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], num_ff[NumW-1]};
      if (start) begin
         num_in  = {num, 8'd0};
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 7'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            rem_in = trial - {1'b0, den};
            q_in   = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = (q_ff[NumW-1:40] != '0) ? '1 : q_ff[39:0];
endmodule

@@ rtl/core/latency_percentile_stats.sv @@
// Streaming latency statistics over a sorted chain of cells.
// Input channel req_valid/req_ready carries one latency word (req_latency_us).
// Result channel rsp_valid/rsp_ready carries count, Q.8 mean, min, max, the
// 50th/95th/99th percentiles of the stored words and store_full.
// One word is in work at a time. After the accepting edge the word is inserted
// into the cell row if it has room (ST_SHIFT), the bit-serial divider forms the
// mean and hands over its quotient (ST_DIV), the percentile indices are computed
// (ST_PICK), the cell row is read in ST_READ and ST_READ_TAIL, and the result
// register is loaded in ST_OUT, which raises rsp_valid. The next word is accepted
// once the result register holds the previous word's result, even while the
// receiver stalls it; the block then waits until the result is taken before
// publishing again. Results stay stable while rsp_valid is high.
// Reset (synchronous, active high) clears count, sum, max, the stored count
// and sets min to all ones; the cell contents need no clearing since only
// entries below the stored count are read.
`include "latency_percentile_stats_assert.svh"
module latency_percentile_stats #(
   parameter int MAX_SAMPLES = lps_pkg::MaxSamples
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_latency_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sample_count,
   output logic [39:0] rsp_average_q8,
   output logic [31:0] rsp_min_latency,
   output logic [31:0] rsp_max_latency,
   output logic [31:0] rsp_p50_latency,
   output logic [31:0] rsp_p95_latency,
   output logic [31:0] rsp_p99_latency,
   output logic        rsp_store_full
);
   localparam int IdxW = $clog2(MAX_SAMPLES);
   localparam int StW  = $clog2(MAX_SAMPLES + 1);

   lps_pkg::state_type state_ff, state_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] seen_ff, seen_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] min_ff, min_in, max_ff, max_in;
   logic [StW-1:0] stored_ff, stored_in;
   logic [IdxW-1:0] i50_ff, i95_ff, i99_ff, i50_in, i95_in, i99_in;
   logic [31:0] p50_ff, p95_ff, p99_ff, p50_in, p95_in, p99_in;
   logic [39:0] avg_ff, avg_in;
   logic rv_ff, rv_in;
   logic [31:0] o_cnt_ff, o_min_ff, o_max_ff, o_p50_ff, o_p95_ff, o_p99_ff;
   logic [39:0] o_avg_ff;
   logic o_full_ff, publish, insert, div_start, div_done;
   logic [39:0] div_q;
   logic [64:0] sum_add;
   logic [StW+6:0] prod50, prod95, prod99;
   logic [StW+26:0] scl50, scl95, scl99;

   logic [31:0] cell_val [MAX_SAMPLES];
   logic        cell_takes [MAX_SAMPLES];

   // Row of cells; cell 0 has no left neighbor.
   for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
      logic        lt;
      logic [31:0] lv;
      if (g == 0) begin : g_first
         assign lt = 1'b0;
         assign lv = '0;
      end else begin : g_rest
         assign lt = cell_takes[g-1];
         assign lv = cell_val[g-1];
      end
      lps_cell u_cell (
         .clock     (clock),
         .insert    (insert),
         .valid_here(StW'(g) < stored_ff),
         .left_takes(lt),
         .left_value(lv),
         .new_value (word_ff),
         .takes     (cell_takes[g]),
         .value     (cell_val[g])
      );
   end

   lps_divider u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (sum_ff),
      .den  (seen_ff),
      .done (div_done),
      .quot (div_q)
   );

   assign sum_add = {1'b0, sum_ff} + {33'd0, req_latency_us};
   assign req_ready = (state_ff == lps_pkg::ST_IDLE);
   assign prod50 = (StW+7)'(stored_ff - StW'(1)) * (StW+7)'(lps_pkg::PctMedian);
   assign prod95 = (StW+7)'(stored_ff - StW'(1)) * (StW+7)'(lps_pkg::PctHigh);
   assign prod99 = (StW+7)'(stored_ff - StW'(1)) * (StW+7)'(lps_pkg::PctTail);
   // Scale by the reciprocal of 100; the index sits above the shift.
   assign scl50 = (StW+27)'(prod50) * (StW+27)'(lps_pkg::PctRecip);
   assign scl95 = (StW+27)'(prod95) * (StW+27)'(lps_pkg::PctRecip);
   assign scl99 = (StW+27)'(prod99) * (StW+27)'(lps_pkg::PctRecip);

   // Sequence one word: stats, insert, divide, index, read, publish.
   always_comb begin
      state_in = state_ff;
      word_in = word_ff; seen_in = seen_ff; sum_in = sum_ff;
      min_in = min_ff; max_in = max_ff; stored_in = stored_ff;
      i50_in = i50_ff; i95_in = i95_ff; i99_in = i99_ff;
      p50_in = p50_ff; p95_in = p95_ff; p99_in = p99_ff;
      avg_in = avg_ff;
      insert = 1'b0; div_start = 1'b0; publish = 1'b0;
      rv_in = rv_ff && !rsp_ready;
      unique case (state_ff)
         lps_pkg::ST_IDLE: begin
            if (req_valid) begin
               word_in = req_latency_us;
               if (seen_ff != '1) seen_in = seen_ff + 32'd1;
               sum_in = sum_add[64] ? '1 : sum_add[63:0];
               if (req_latency_us < min_ff) min_in = req_latency_us;
               if (req_latency_us > max_ff) max_in = req_latency_us;
               state_in = lps_pkg::ST_SHIFT;
            end
         end
         lps_pkg::ST_SHIFT: begin
            if (stored_ff < StW'(MAX_SAMPLES)) begin
               insert = 1'b1;
               stored_in = stored_ff + StW'(1);
            end
            div_start = 1'b1;
            state_in = lps_pkg::ST_DIV;
         end
         lps_pkg::ST_DIV: begin
            if (div_done) begin
               avg_in = div_q;
               state_in = lps_pkg::ST_PICK;
            end
         end
         lps_pkg::ST_PICK: begin
            i50_in = scl50[lps_pkg::PctShift +: IdxW];
            i95_in = scl95[lps_pkg::PctShift +: IdxW];
            i99_in = scl99[lps_pkg::PctShift +: IdxW];
            state_in = lps_pkg::ST_READ;
         end
         lps_pkg::ST_READ: begin
            p50_in = cell_val[i50_ff];
            p95_in = cell_val[i95_ff];
            state_in = lps_pkg::ST_READ_TAIL;
         end
         lps_pkg::ST_READ_TAIL: begin
            p99_in = cell_val[i99_ff];
            state_in = lps_pkg::ST_OUT;
         end
         lps_pkg::ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               publish = 1'b1;
               rv_in = 1'b1;
               state_in = lps_pkg::ST_IDLE;
            end
         end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lps_pkg::ST_IDLE;
         seen_ff <= '0;
         sum_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
         stored_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
         sum_ff <= sum_in;
         min_ff <= min_in;
         max_ff <= max_in;
         stored_ff <= stored_in;
         rv_ff <= rv_in;
      end
      word_ff <= word_in;
      i50_ff <= i50_in; i95_ff <= i95_in; i99_ff <= i99_in;
      p50_ff <= p50_in; p95_ff <= p95_in; p99_ff <= p99_in;
      avg_ff <= avg_in;
      // Hold the result word until the receiver takes it.
      if (publish) begin
         o_cnt_ff <= seen_ff; o_avg_ff <= avg_ff;
         o_min_ff <= min_ff; o_max_ff <= max_ff;
         o_p50_ff <= p50_ff; o_p95_ff <= p95_ff; o_p99_ff <= p99_ff;
         o_full_ff <= (stored_ff >= StW'(MAX_SAMPLES));
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_sample_count = o_cnt_ff;
   assign rsp_average_q8 = o_avg_ff;
   assign rsp_min_latency = o_min_ff;
   assign rsp_max_latency = o_max_ff;
   assign rsp_p50_latency = o_p50_ff;
   assign rsp_p95_latency = o_p95_ff;
   assign rsp_p99_latency = o_p99_ff;
   assign rsp_store_full = o_full_ff;

   `LPS_ASSERT_ALWAYS(a_stored_bound, stored_ff <= StW'(MAX_SAMPLES), "stored count overflow")
   `LPS_ASSERT_ALWAYS(a_min_max, seen_ff == '0 || min_ff <= max_ff, "min above max")
   `LPS_ASSERT_NEXT(a_publish, publish, rsp_valid, "published word not valid")
endmodule

@@ dv/tb_top.sv @@
module tb_top;
   localparam int StallLimit = 5000;
   localparam int DrainPoint = 300;
   localparam int QuietTail = 60;

   typedef struct packed {
      logic [lps_pkg::CntW-1:0]  sample_count;
      logic [lps_pkg::AvgW-1:0]  average_q8;
      logic [lps_pkg::DataW-1:0] min_latency;
      logic [lps_pkg::DataW-1:0] max_latency;
      logic [lps_pkg::DataW-1:0] p50_latency;
      logic [lps_pkg::DataW-1:0] p95_latency;
      logic [lps_pkg::DataW-1:0] p99_latency;
      logic                      store_full;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_latency_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_sample_count;
   logic [39:0] rsp_average_q8;
   logic [31:0] rsp_min_latency;
   logic [31:0] rsp_max_latency;
   logic [31:0] rsp_p50_latency;
   logic [31:0] rsp_p95_latency;
   logic [31:0] rsp_p99_latency;
   logic rsp_store_full;

   latency_percentile_stats u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_latency_us(req_latency_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sample_count(rsp_sample_count), .rsp_average_q8(rsp_average_q8),
      .rsp_min_latency(rsp_min_latency), .rsp_max_latency(rsp_max_latency),
      .rsp_p50_latency(rsp_p50_latency), .rsp_p95_latency(rsp_p95_latency),
      .rsp_p99_latency(rsp_p99_latency), .rsp_store_full(rsp_store_full)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // statistics predictor state
   logic [lps_pkg::DataW-1:0] sorted_words [lps_pkg::MaxSamples];
   int unsigned               kept_words = 0;
   logic [lps_pkg::CntW-1:0]  seen_words = '0;
   logic [lps_pkg::SumW-1:0]  word_sum = '0;
   logic [lps_pkg::DataW-1:0] low_word = '1;
   logic [lps_pkg::DataW-1:0] high_word = '0;

   logic [31:0] pending_words [$];
   stats_type   expected_stats [$];
   int          sent_words = 0;
   int          errors = 0;

   // append one word to the stimulus queue
   function automatic void queue_word(logic [31:0] w);
      pending_words = {pending_words, w};
   endfunction

   function automatic logic [lps_pkg::DataW-1:0] pick_rank(int unsigned pct);
      int unsigned idx;
      idx = ((kept_words - 1) * pct) / 100;
      return sorted_words[idx];
   endfunction

   // fold one word into the running statistics and return the new summary
   function automatic stats_type update_stats(logic [31:0] w);
      stats_type s;
      int unsigned pos;
      logic [71:0] quot, remd;
      if (seen_words != '1) seen_words = seen_words + 1;
      if (word_sum > ({lps_pkg::SumW{1'b1}} - lps_pkg::SumW'(w))) word_sum = '1;
      else word_sum = word_sum + lps_pkg::SumW'(w);
      if (w < low_word) low_word = w;
      if (w > high_word) high_word = w;
      // insert after any equal entries; drop once full
      if (kept_words < lps_pkg::MaxSamples) begin
         pos = kept_words;
         while (pos > 0 && sorted_words[pos-1] > w) begin
            sorted_words[pos] = sorted_words[pos-1];
            pos--;
         end
         sorted_words[pos] = w;
         kept_words++;
      end
      quot = 72'(word_sum) / 72'(seen_words);
      remd = 72'(word_sum) % 72'(seen_words);
      s.sample_count = seen_words;
      if (quot >= 72'h1_0000_0000) s.average_q8 = '1;
      else s.average_q8 = lps_pkg::AvgW'((quot << 8) + ((remd << 8) / 72'(seen_words)));
      s.min_latency = low_word;
      s.max_latency = high_word;
      s.p50_latency = pick_rank(lps_pkg::PctMedian);
      s.p95_latency = pick_rank(lps_pkg::PctHigh);
      s.p99_latency = pick_rank(lps_pkg::PctTail);
      s.store_full = (kept_words >= lps_pkg::MaxSamples);
      return s;
   endfunction

   // sender: hold word until accepted, predict on accept, idle in bursts
   int send_gap = 0;
   always @(posedge clock) begin
      logic fire;
      logic [31:0] nxt;
      stats_type pred;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         req_valid <= 1'b1;
      end else begin
         if (fire) begin
            pred = update_stats(req_latency_us);
            expected_stats = {expected_stats, pred};
            sent_words++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (sent_words == DrainPoint && (fire || expected_stats.size() != 0)) begin
            // hold off until every outstanding result is back
            req_valid <= 1'b0;
         end else if (pending_words.size() > QuietTail && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 8) - 1;
            req_valid <= 1'b0;
         end else begin
            nxt = pending_words.pop_front();
            req_valid <= 1'b1;
            req_latency_us <= nxt;
         end
      end
   end

   // receiver: check each accepted word against the oldest prediction
   int recv_gap = 0;
   always @(posedge clock) begin
      stats_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_sample_count, rsp_average_q8, rsp_min_latency, rsp_max_latency,
                    rsp_p50_latency, rsp_p95_latency, rsp_p99_latency, rsp_store_full};
            if (expected_stats.size() == 0) begin
               $display("%0t: unexpected result word %p", $time, got);
               errors++;
            end else begin
               want = expected_stats.pop_front();
               if (got.sample_count !== want.sample_count) begin
                  $display("%0t: sample_count exp %0d got %0d", $time,
                           want.sample_count, got.sample_count);
                  errors++;
               end
               if (got.average_q8 !== want.average_q8) begin
                  $display("%0t: average_q8 exp %0h got %0h", $time,
                           want.average_q8, got.average_q8);
                  errors++;
               end
               if (got.min_latency !== want.min_latency) begin
                  $display("%0t: min_latency exp %0h got %0h", $time,
                           want.min_latency, got.min_latency);
                  errors++;
               end
               if (got.max_latency !== want.max_latency) begin
                  $display("%0t: max_latency exp %0h got %0h", $time,
                           want.max_latency, got.max_latency);
                  errors++;
               end
               if (got.p50_latency !== want.p50_latency) begin
                  $display("%0t: p50_latency exp %0h got %0h", $time,
                           want.p50_latency, got.p50_latency);
                  errors++;
               end
               if (got.p95_latency !== want.p95_latency) begin
                  $display("%0t: p95_latency exp %0h got %0h", $time,
                           want.p95_latency, got.p95_latency);
                  errors++;
               end
               if (got.p99_latency !== want.p99_latency) begin
                  $display("%0t: p99_latency exp %0h got %0h", $time,
                           want.p99_latency, got.p99_latency);
                  errors++;
               end
               if (got.store_full !== want.store_full) begin
                  $display("%0t: store_full exp %0b got %0b", $time,
                           want.store_full, got.store_full);
                  errors++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (pending_words.size() > QuietTail && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] w;
      // directed: extremes, ties, single bits
      queue_word(32'd0);
      queue_word(32'hFFFF_FFFF);
      queue_word(32'hFFFF_FFFF);
      queue_word(32'd0);
      queue_word(32'd7);
      queue_word(32'd7);
      queue_word(32'd7);
      queue_word(32'h8000_0000);
      queue_word(32'h7FFF_FFFF);
      queue_word(32'h5555_5555);
      queue_word(32'hAAAA_AAAA);
      queue_word(32'd1);
      queue_word(32'hFFFF_FFFE);
      queue_word(32'd100);
      queue_word(32'd99);
      // random: full range, small values with many ties, values up to 5000, and values near the top
      for (int i = 0; i < 690; i++) begin
         case ($urandom_range(0, 3))
            0: w = $urandom();
            1: w = $urandom_range(0, 20);
            2: w = $urandom_range(0, 5000);
            default: w = 32'hFFFF_FFFF - $urandom_range(0, 1000);
         endcase
         queue_word(w);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && !req_valid && expected_stats.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_stats.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_cell.sv
rtl/core/lps_divider.sv
rtl/core/latency_percentile_stats.sv
dv/tb_top.sv
